// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFIR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sfir_pkg.sv -----
// ----------------------------------------------------------------------------
// sfir_pkg
// shared types and constants of the symmetric complex fir
// ----------------------------------------------------------------------------
package sfir_pkg;

    localparam int unsigned DATA_W    = 16;
    localparam int unsigned COEFF_W   = 16;
    localparam int unsigned PRE_W     = DATA_W + 1;
    localparam int unsigned PROD_W    = PRE_W + COEFF_W;
    localparam int unsigned NCOEFF    = 8;
    localparam int unsigned CFG_IDX_W = $clog2(NCOEFF);
    localparam int unsigned TAPS_DEF  = 16;
    localparam int unsigned SHIFT_DEF = 15;

    localparam logic signed [COEFF_W-1:0] COEFF_RESET [NCOEFF] = '{
        -16'sd29, -16'sd115, -16'sd122, 16'sd268,
        16'sd1379, 16'sd3209, 16'sd5226, 16'sd6566
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] im;
        logic signed [DATA_W-1:0] re;
    } sample_t;

endpackage

// ----- rtl/core/sfir_in_if.sv -----
// ----------------------------------------------------------------------------
// sfir_in_if
// input sample channel, valid/ready with complex payload
// ----------------------------------------------------------------------------
interface sfir_in_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [sfir_pkg::DATA_W-1:0]   in_re;
    logic signed [sfir_pkg::DATA_W-1:0]   in_im;

    modport source (output valid, output in_re, output in_im, input ready);
    modport sink   (input valid, input in_re, input in_im, output ready);

endinterface

// ----- rtl/core/sfir_out_if.sv -----
// ----------------------------------------------------------------------------
// sfir_out_if
// filtered sample channel, valid/ready with complex payload
// ----------------------------------------------------------------------------
interface sfir_out_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [sfir_pkg::DATA_W-1:0]   out_re;
    logic signed [sfir_pkg::DATA_W-1:0]   out_im;

    modport source (output valid, output out_re, output out_im, input ready);
    modport sink   (input valid, input out_re, input out_im, output ready);

endinterface

// ----- rtl/core/sfir_tap_cell.sv -----
// ----------------------------------------------------------------------------
// sfir_tap_cell
// one delay line stage, shifts its sample to the neighbor on each request
// ----------------------------------------------------------------------------
module sfir_tap_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  sfir_pkg::sample_t din,
    output sfir_pkg::sample_t dout
);
    import sfir_pkg::*;

    sample_t tap_reg;
    sample_t tap_next;

    always_comb
    begin
        tap_next = shift ? din : tap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
        end
    end

    assign dout = tap_reg;

endmodule

// ----- rtl/core/sfir_mac_cell.sv -----
// ----------------------------------------------------------------------------
// sfir_mac_cell
// one mirrored tap pair: registered pre-add, then registered multiply
// ----------------------------------------------------------------------------
module sfir_mac_cell (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [sfir_pkg::COEFF_W-1:0]  coeff,
    input  sfir_pkg::sample_t                    tap_a,
    input  sfir_pkg::sample_t                    tap_b,
    output logic signed [sfir_pkg::PROD_W-1:0]   prod_re,
    output logic signed [sfir_pkg::PROD_W-1:0]   prod_im
);
    import sfir_pkg::*;

    logic signed [PRE_W-1:0]  pre_re_reg;
    logic signed [PRE_W-1:0]  pre_im_reg;
    logic signed [PRE_W-1:0]  pre_re_next;
    logic signed [PRE_W-1:0]  pre_im_next;
    logic signed [PROD_W-1:0] prod_re_reg;
    logic signed [PROD_W-1:0] prod_im_reg;
    logic signed [PROD_W-1:0] prod_re_next;
    logic signed [PROD_W-1:0] prod_im_next;

    always_comb
    begin
        pre_re_next  = PRE_W'(tap_a.re) + PRE_W'(tap_b.re);
        pre_im_next  = PRE_W'(tap_a.im) + PRE_W'(tap_b.im);
        prod_re_next = PROD_W'(pre_re_reg) * PROD_W'(coeff);
        prod_im_next = PROD_W'(pre_im_reg) * PROD_W'(coeff);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_re_reg  <= pre_re_next;
            pre_im_reg  <= pre_im_next;
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
    end

    assign prod_re = prod_re_reg;
    assign prod_im = prod_im_reg;

endmodule

// ----- rtl/core/sfir_add_tree.sv -----
// ----------------------------------------------------------------------------
// sfir_add_tree
// registered binary adder tree over the pair products, with a register on every level
// ----------------------------------------------------------------------------
module sfir_add_tree #(
    parameter int unsigned N     = 8,
    parameter int unsigned SUM_W = sfir_pkg::PROD_W + $clog2(N)
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [sfir_pkg::PROD_W-1:0]  leaf [N],
    output logic signed [SUM_W-1:0]             root
);
    import sfir_pkg::*;

    localparam int unsigned LV     = $clog2(N);
    localparam int unsigned LEAVES = 1 << LV;

    logic signed [SUM_W-1:0] node [1:2*LEAVES-1];

    for (genvar i = LEAVES; i < 2 * LEAVES; i++)
    begin : g_leaf
        if (i - LEAVES < N)
        begin : g_used
            assign node[i] = SUM_W'(leaf[i-LEAVES]);
        end
        else
        begin : g_pad
            assign node[i] = '0;
        end
    end

    for (genvar i = 1; i < LEAVES; i++)
    begin : g_node
        logic signed [SUM_W-1:0] sum_reg;
        logic signed [SUM_W-1:0] sum_next;

        assign sum_next = node[2*i] + node[2*i+1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sum_reg <= sum_next;
            end
        end

        assign node[i] = sum_reg;
    end

    assign root = node[1];

endmodule

// ----- rtl/core/symmetric_fir_16tap_complex.sv -----
// ----------------------------------------------------------------------------
// symmetric_fir_16tap_complex
// symmetric fir on a complex stream, real and imaginary parts filtered alike
// ----------------------------------------------------------------------------
// One complex sample is accepted every clock cycle unless the output stalls,
// and one filtered sample leaves for each. Samples walk down a chain of TAPS
// delay cells; each of the min(TAPS/2, 8) pair cells pre-adds its mirrored
// taps, registers, multiplies by its coefficient and registers again, and a
// registered adder tree sums the products. The sum is shifted right by SHIFT
// (floor) and saturated to 16 bits in the output register. A stall at the
// output freezes the whole pipe and the delay line. Coefficients are written
// through cfg_we/cfg_idx/cfg_data; the user must do so only while the filter
// is empty, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module symmetric_fir_16tap_complex #(
    parameter int unsigned TAPS  = sfir_pkg::TAPS_DEF,
    parameter int unsigned SHIFT = sfir_pkg::SHIFT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [sfir_pkg::COEFF_W-1:0]          cfg_data,
    sfir_in_if.sink                               sample_in,
    sfir_out_if.source                            sample_out
);
    import sfir_pkg::*;

    localparam int unsigned NPAIR   = TAPS / 2;
    localparam int unsigned NM      = (NPAIR < NCOEFF) ? NPAIR : NCOEFF;
    localparam int unsigned TREE_LV = $clog2(NM);
    localparam int unsigned SUM_W   = PROD_W + TREE_LV;
    localparam int unsigned DEPTH   = 4 + TREE_LV;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2 ** (DATA_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    logic                        en;
    logic                        accept;
    logic [DEPTH-1:0]            valid_reg;
    logic [DEPTH-1:0]            valid_next;
    logic signed [COEFF_W-1:0]   coeff_reg [NCOEFF];
    sample_t                     din;
    sample_t                     tap [TAPS];
    logic signed [PROD_W-1:0]    prod_re [NM];
    logic signed [PROD_W-1:0]    prod_im [NM];
    logic signed [SUM_W-1:0]     sum_re;
    logic signed [SUM_W-1:0]     sum_im;
    logic signed [SUM_W-1:0]     shr_re;
    logic signed [SUM_W-1:0]     shr_im;
    logic signed [DATA_W-1:0]    out_re_reg;
    logic signed [DATA_W-1:0]    out_im_reg;
    logic signed [DATA_W-1:0]    out_re_next;
    logic signed [DATA_W-1:0]    out_im_next;

    assign en     = !valid_reg[DEPTH-1] || sample_out.ready;
    assign accept = sample_in.valid && en;
    assign sample_in.ready = en;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= COEFF_RESET;
        end
        else if (cfg_we)
        begin
            coeff_reg[cfg_idx] <= cfg_data;
        end
    end

    // delay line
    assign din.re = sample_in.in_re;
    assign din.im = sample_in.in_im;

    for (genvar i = 0; i < TAPS; i++)
    begin : g_tap
        if (i == 0)
        begin : g_head
            sfir_tap_cell u_tap (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (accept),
                .din   (din),
                .dout  (tap[i])
            );
        end
        else
        begin : g_body
            sfir_tap_cell u_tap (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (accept),
                .din   (tap[i-1]),
                .dout  (tap[i])
            );
        end
    end

    // pair cells
    for (genvar k = 0; k < NM; k++)
    begin : g_mac
        sfir_mac_cell u_mac (
            .clk     (clk),
            .en      (en),
            .coeff   (coeff_reg[k]),
            .tap_a   (tap[k]),
            .tap_b   (tap[TAPS-1-k]),
            .prod_re (prod_re[k]),
            .prod_im (prod_im[k])
        );
    end

    sfir_add_tree #(
        .N     (NM),
        .SUM_W (SUM_W)
    ) u_tree_re (
        .clk  (clk),
        .en   (en),
        .leaf (prod_re),
        .root (sum_re)
    );

    sfir_add_tree #(
        .N     (NM),
        .SUM_W (SUM_W)
    ) u_tree_im (
        .clk  (clk),
        .en   (en),
        .leaf (prod_im),
        .root (sum_im)
    );

    // floor shift and saturation
    always_comb
    begin
        shr_re = sum_re >>> SHIFT;
        shr_im = sum_im >>> SHIFT;
        if (shr_re > SAT_MAX)
        begin
            out_re_next = DATA_W'(SAT_MAX);
        end
        else if (shr_re < SAT_MIN)
        begin
            out_re_next = DATA_W'(SAT_MIN);
        end
        else
        begin
            out_re_next = DATA_W'(shr_re);
        end
        if (shr_im > SAT_MAX)
        begin
            out_im_next = DATA_W'(SAT_MAX);
        end
        else if (shr_im < SAT_MIN)
        begin
            out_im_next = DATA_W'(SAT_MIN);
        end
        else
        begin
            out_im_next = DATA_W'(shr_im);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
        end
    end

    // pipeline valid tracking
    always_comb
    begin
        valid_next = valid_reg;
        if (en)
        begin
            valid_next = {valid_reg[DEPTH-2:0], sample_in.valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample_out.valid  = valid_reg[DEPTH-1];
    assign sample_out.out_re = out_re_reg;
    assign sample_out.out_im = out_im_reg;

    `SFIR_ASSERT_NEXT(a_accept_enters_pipe, accept, valid_reg[0], "accepted request not in pipe")
    `SFIR_ASSERT_NEXT(a_stall_freezes, !en, $stable(tap[0]) && $stable(valid_reg), "pipe moved")
    `SFIR_ASSERT_IMPL(a_result_src, $rose(sample_out.valid), $past(valid_reg[DEPTH-2]), "no request")

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the symmetric complex fir
// ----------------------------------------------------------------------------
// Complex samples are streamed through valid/ready channels. Random gaps
// appear on both sides, and one phase holds the output off for a long
// stretch. A predictor keeps its own delay line and coefficients and
// computes each filtered sample: pre-add of the mirrored taps, exact sum,
// floor shift and saturation. Every output is compared field by field in
// order. Coefficients are reloaded between phases while the filter is
// empty. The coefficient sets include the reset values, both rails and random sets.
// ----------------------------------------------------------------------------
module testbench;

    import sfir_pkg::*;

    localparam int PIPE_LATENCY = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 150;
    localparam int REPORT_MAX   = 200;

    class fir_predictor;
        sample_t                    taps [TAPS_DEF];
        logic signed [COEFF_W-1:0]  coeff [NCOEFF];
        sample_t                    pending_outputs [$];
        int                         errors;
        int                         checked;
        int                         reported;

        function new();
            for (int i = 0; i < TAPS_DEF; i++)
            begin
                taps[i] = '0;
            end
            for (int k = 0; k < NCOEFF; k++)
            begin
                coeff[k] = COEFF_RESET[k];
            end
            errors   = 0;
            checked  = 0;
            reported = 0;
        endfunction

        function void set_coeff(int idx, logic signed [COEFF_W-1:0] value);
            coeff[idx] = value;
        endfunction

        function logic signed [DATA_W-1:0] tap_sum(bit use_im);
            longint acc;
            longint a;
            longint b;
            acc = 0;
            for (int k = 0; k < TAPS_DEF / 2; k++)
            begin
                a = use_im ? $signed(taps[k].im) : $signed(taps[k].re);
                b = use_im ? $signed(taps[TAPS_DEF-1-k].im) : $signed(taps[TAPS_DEF-1-k].re);
                acc += longint'(coeff[k]) * (a + b);
            end
            acc = acc >>> SHIFT_DEF;
            if (acc > 32767)
                return 16'sh7fff;
            else if (acc < -32768)
                return 16'sh8000;
            return acc[DATA_W-1:0];
        endfunction

        function void push_sample(sample_t s);
            sample_t want;
            for (int i = TAPS_DEF - 1; i > 0; i--)
            begin
                taps[i] = taps[i-1];
            end
            taps[0] = s;
            want.re = tap_sum(1'b0);
            want.im = tap_sum(1'b1);
            pending_outputs.push_back(want);
        endfunction

        function void note_error(string what, int want, int got);
            errors++;
            if (reported < REPORT_MAX)
            begin
                reported++;
                $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            end
        endfunction

        function void check_output(logic signed [DATA_W-1:0] re,
                                   logic signed [DATA_W-1:0] im);
            sample_t want;
            if (pending_outputs.size() == 0)
            begin
                errors++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display("%0t: output with nothing expected, expected none got re=%0d im=%0d",
                             $time, re, im);
                end
                return;
            end
            want = pending_outputs.pop_front();
            checked++;
            if (re !== want.re)
                note_error("out_re", $signed(want.re), re);
            if (im !== want.im)
                note_error("out_im", $signed(want.im), im);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_idx;
    logic [COEFF_W-1:0]         cfg_data;

    sfir_in_if  in_if ();
    sfir_out_if out_if ();

    symmetric_fir_16tap_complex uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .sample_in  (in_if),
        .sample_out (out_if)
    );

    fir_predictor               board = new();
    logic signed [COEFF_W-1:0]  next_coeffs [NCOEFF];
    bit                         tx_steady;
    bit                         rx_steady;
    bit                         hold_request;
    int                         sets_loaded;
    int                         cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t make_sample(int re, int im);
        sample_t s;
        s.re = re[DATA_W-1:0];
        s.im = im[DATA_W-1:0];
        return s;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_part();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return DATA_W'($urandom());
        if (r < 85)
            return DATA_W'($urandom_range(0, 512) - 256);
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // one request per call, valid stays high when the next follows directly
    task automatic send_sample(sample_t s);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.in_re <= s.re;
        in_if.in_im <= s.im;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        board.push_sample(s);
    endtask

    task automatic wait_for_outputs();
        in_if.valid <= 1'b0;
        while (board.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic load_coeffs();
        for (int k = 0; k < NCOEFF; k++)
        begin
            cfg_we   <= 1'b1;
            cfg_idx  <= k[CFG_IDX_W-1:0];
            cfg_data <= next_coeffs[k];
            @(posedge clk);
            board.set_coeff(k, next_coeffs[k]);
        end
        cfg_we <= 1'b0;
        sets_loaded++;
    endtask

    task automatic choose_coeffs(int phase);
        int hot;
        hot = $urandom_range(0, NCOEFF - 1);
        for (int k = 0; k < NCOEFF; k++)
        begin
            case (phase)
                1: next_coeffs[k] = COEFF_RESET[k];
                2: next_coeffs[k] = 16'sh7fff;
                3, 8: next_coeffs[k] = COEFF_W'($urandom_range(0, 4096) - 2048);
                4: next_coeffs[k] = (k == hot) ? 16'sh4000 : 16'sh0000;
                5: next_coeffs[k] = 16'sh8000;
                7: next_coeffs[k] = k[0] ? 16'sh8000 : 16'sh7fff;
                default: next_coeffs[k] = COEFF_W'($urandom());
            endcase
        end
    endtask

    // watchdog
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("symmetric_fir_16tap_complex: mismatch");
        $finish;
    end

    // output side, random stalls and the long hold
    initial
    begin : output_side
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready)
                board.check_output(out_if.out_re, out_if.out_im);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_if.ready <= rst_n;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : main_flow
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;
        sets_loaded  = 0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        in_if.valid  <= 1'b0;
        in_if.in_re  <= '0;
        in_if.in_im  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients, rails and sign flips
        for (int i = 0; i < 3; i++)
            send_sample(make_sample(32767, -32768));
        for (int i = 0; i < 3; i++)
            send_sample(make_sample(-32768, 32767));
        send_sample(make_sample(0, 0));
        send_sample(make_sample(1, -1));
        send_sample(make_sample(-1, 1));
        send_sample(make_sample(0, 0));
        wait_for_outputs();

        // most negative coefficients drive the sum past both rails
        for (int k = 0; k < NCOEFF; k++)
            next_coeffs[k] = 16'sh8000;
        load_coeffs();
        for (int i = 0; i < 6; i++)
            send_sample(make_sample(-32768, 32767));
        for (int i = 0; i < 6; i++)
            send_sample(make_sample(32767, -32768));
        wait_for_outputs();

        for (int p = 0; p < PHASES; p++)
        begin
            choose_coeffs(p);
            load_coeffs();
            tx_steady = (p == 3 || p == 5);
            rx_steady = (p == 5);
            if (p == 3)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(make_sample(int'(rand_part()), int'(rand_part())));
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            wait_for_outputs();
        end

        if (board.pending_outputs.size() != 0)
            $display("%0d expected outputs never arrived", board.pending_outputs.size());
        $display("checked %0d filtered samples over %0d coefficient sets", board.checked,
                 sets_loaded);
        $display("saturation at both rails, a %0d-cycle output hold, gapped and steady streams",
                 HOLD_CYCLES);
        if (board.errors == 0 && board.pending_outputs.size() == 0)
            $display("symmetric_fir_16tap_complex: match");
        else
            $display("symmetric_fir_16tap_complex: mismatch");
        $finish;
    end

endmodule

// ----- symmetric_fir_16tap_complex.f -----
+incdir+rtl/core
rtl/core/sfir_pkg.sv
rtl/core/sfir_in_if.sv
rtl/core/sfir_out_if.sv
rtl/core/sfir_tap_cell.sv
rtl/core/sfir_mac_cell.sv
rtl/core/sfir_add_tree.sv
rtl/core/symmetric_fir_16tap_complex.sv
verif/testbench.sv
